FILE: hdl/ghc_pkg.sv
package ghc_pkg;

  localparam int MAX_LAYERS      = 8;
  localparam int EDGES_PER_LAYER = 6;
  localparam int WORDS_PER_LAYER = 32;
  localparam int WORD_W          = $clog2(WORDS_PER_LAYER);
  localparam int LAYER_W         = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int BOX_BASE        = 3 * EDGES_PER_LAYER;
  localparam int GRAD_BASE       = BOX_BASE + 4;
  localparam int COL_BASE        = GRAD_BASE + 5;
  localparam int SAMP_W          = 26;
  localparam int COV_W           = 17;
  localparam int ACC_W           = 57;
  localparam int ACT_W           = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 24;

  localparam logic [COV_W-1:0]      ONE_Q16      = 17'd65536;
  localparam logic [COV_W-1:0]      TRANSP_STOP  = 17'd131;
  localparam logic [23:0]           BG_RESET     = 24'h361D48;
  localparam logic [ACT_W-1:0]      ACTIVE_RESET = 4'd6;
  localparam logic [CFG_IDX_W-1:0]  CFG_BACKGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_ACTIVE     = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SHADE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         layer_index;
    logic [4:0]         word_index;
    logic signed [31:0] word_value;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
  } in_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        touched;
  } out_t;

  // request that travels down the row of layer cells
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [LAYER_W-1:0] layer;
    logic [WORD_W-1:0]  word;
    logic [31:0]        data;
  } req_t;

endpackage

FILE: hdl/gradient_hexagon_compositor_unit.sv
// Antialiased hexagon compositor. A beat with cmd 0 writes one 32-bit word of
// a layer's parameters (edges, box, gradient, colours) into a row of eight
// layer cells, and the block takes the next beat at once. A beat with cmd 1
// shades the pixel centre against the active layers, front (highest index)
// to back, and yields one result beat with the composited colour and a
// touched flag. Shading goes through one shared datapath that fetches
// parameter words one at a time from the cell row; a layer that misses its
// box or that an edge rejects is left early. The pass ends early once
// transparency falls to about 0.002. While a pixel is shaded the input is
// stalled; a finished result waits in the output register while the next
// beat is taken. Configuration writes (background colour, layer count) are
// taken in any cycle and belong in idle time. Parameter words read back as
// undefined until written, so every word a shade uses must be loaded first.
module gradient_hexagon_compositor_unit import ghc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [23:0]      bg_q;
  logic [ACT_W-1:0] act_q;
  logic             busy;
  logic             in_acc;
  req_t             wr_req;
  req_t             shade_req;
  req_t             req_chain [MAX_LAYERS+1];
  logic [31:0]      rd_chain  [MAX_LAYERS+1];

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q  <= BG_RESET;
      act_q <= ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BACKGROUND: bg_q  <= cfg_data_i[23:0];
        CFG_ACTIVE:     act_q <= cfg_data_i[ACT_W-1:0];
        default:        ;
      endcase
    end
  end

  // input beats are taken only while the shader is idle
  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    wr_req       = '0;
    wr_req.wr    = in_acc && (in_i.cmd == CMD_WRITE) &&
                   (32'(in_i.layer_index) < 32'(MAX_LAYERS));
    wr_req.layer = LAYER_W'(in_i.layer_index);
    wr_req.word  = in_i.word_index;
    wr_req.data  = in_i.word_value;
  end

  // the row of layer cells: requests run down, read data runs back out
  assign req_chain[0] = busy ? shade_req : wr_req;
  assign rd_chain[0]  = '0;

  for (genvar i = 0; i < MAX_LAYERS; i++) begin : g_cell
    ghc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req_chain[i]),
      .req_o   (req_chain[i+1]),
      .rdata_i (rd_chain[i]),
      .rdata_o (rd_chain[i+1])
    );
  end

  // shading sequencer and output register
  ghc_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc && (in_i.cmd == CMD_SHADE)),
    .x_i         (in_i.pixel_x),
    .y_i         (in_i.pixel_y),
    .bg_i        (bg_q),
    .act_i       (act_q),
    .busy_o      (busy),
    .req_o       (shade_req),
    .rdata_i     (rd_chain[MAX_LAYERS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

FILE: hdl/ghc_cell.sv
module ghc_cell import ghc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  output req_t        req_o,
  input  logic [31:0] rdata_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [WORDS_PER_LAYER];
  logic [31:0] rd_q;
  logic        hit_q;
  logic        hit;

  // this cell answers when the layer count has run down to zero
  assign hit = (req_i.wr | req_i.rd) && (req_i.layer == '0);

  always_comb begin
    req_o       = req_i;
    req_o.layer = req_i.layer - LAYER_W'(1);
    if (hit) begin
      req_o.wr = 1'b0;
      req_o.rd = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && req_i.wr) begin
      mem_q[req_i.word] <= req_i.data;
    end
    rd_q <= mem_q[req_i.word];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit && req_i.rd;
    end
  end

  assign rdata_o = hit_q ? rd_q : rdata_i;

endmodule

FILE: hdl/ghc_shade.sv
module ghc_shade import ghc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [9:0]       x_i,
  input  logic [9:0]       y_i,
  input  logic [23:0]      bg_i,
  input  logic [ACT_W-1:0] act_i,
  output logic             busy_o,
  output req_t             req_o,
  input  logic [31:0]      rdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_o
);

  localparam int PROD_W = 32 + SAMP_W + 1;
  localparam logic signed [63:0] POS_HALF = 64'sd2147483648;
  localparam logic signed [63:0] NEG_HALF = -64'sd2147483648;
  localparam logic signed [33:0] HALF34   = 34'sd32768;
  localparam logic signed [33:0] SAT_HI   = 34'sd2147483647;
  localparam logic signed [33:0] SAT_LO   = -34'sd2147483647;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_USE, ST_GH, ST_GL, ST_GS, ST_W, ST_C, ST_M, ST_T, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_BOX, PH_EDGE, PH_GRAD, PH_COL
  } phase_e;

  function automatic logic [7:0] chan(input logic [23:0] rgb, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = rgb[23:16];
      2'd1:    v = rgb[15:8];
      default: v = rgb[7:0];
    endcase
    return v;
  endfunction

  state_e             state_q;
  phase_e             ph_q;
  logic [LAYER_W-1:0] k_q;
  logic [WORD_W-1:0]  word_q;
  logic [2:0]         sub_q;
  logic               fail_q;
  logic [SAMP_W-1:0]  sx_q, sy_q;
  logic [COV_W-1:0]   t_q, cover_q, g_q;
  logic signed [63:0] dsum_q, prod_q;
  logic [63:0]        lp_q;
  logic signed [31:0] dx_q, dy_q;
  logic [31:0]        gabs_q;
  logic [23:0]        ca_q, cb_q, c_q;
  logic [32:0]        w_q;
  logic [1:0]         ch_q;
  logic [ACC_W-1:0]   acc_q [3];
  logic               out_valid_q;
  out_t               out_q;

  logic signed [31:0]       rd_s;
  logic signed [33:0]       sxe, sye, rde, dxs;
  logic                     box_fail;
  logic [SAMP_W-1:0]        samp;
  logic signed [PROD_W-1:0] eprod;
  logic signed [63:0]       gprod, dval, dh;
  logic [COV_W-1:0]         ce, new_cov;
  logic signed [31:0]       dsat;
  logic                     g_zero;
  logic signed [63:0]       mabs;
  logic [63:0]              gsum;
  logic [COV_W-1:0]         gsel;
  logic [24:0]              cmix;
  logic [33:0]              tn_full;
  logic [COV_W-1:0]         tn;
  logic [23:0]              fin_rgb;
  logic [4:0]               n_act;
  logic                     last_layer;

  always_comb begin
    logic [ACC_W-1:0] fs;
    logic [24:0]      bgp;
    rd_s     = $signed(rdata_i);
    sxe      = $signed(34'(sx_q));
    sye      = $signed(34'(sy_q));
    rde      = 34'(rd_s);
    case (sub_q)
      3'd0:    box_fail = (sxe + HALF34) < rde;
      3'd1:    box_fail = (sye + HALF34) < rde;
      3'd2:    box_fail = (sxe - HALF34) > rde;
      default: box_fail = (sye - HALF34) > rde;
    endcase
    samp     = (sub_q == 3'd0) ? sx_q : sy_q;
    eprod    = rd_s * $signed({1'b0, samp});
    gprod    = ((sub_q == 3'd2) ? dx_q : dy_q) * rd_s;
    dval     = dsum_q + $signed({{16{rdata_i[31]}}, rdata_i, 16'h0000});
    dh       = dval + POS_HALF;
    ce       = (dval >= POS_HALF) ? ONE_Q16 : dh[32:16];
    new_cov  = (ce < cover_q) ? ce : cover_q;
    dxs      = ((sub_q == 3'd0) ? sxe : sye) - rde;
    if (dxs > SAT_HI) dsat = 32'sh7FFFFFFF;
    else if (dxs < SAT_LO) dsat = 32'sh80000001;
    else dsat = dxs[31:0];
    g_zero   = (dsum_q == 64'sd0) || (rdata_i == 32'd0) || (dsum_q[63] != rdata_i[31]);
    mabs     = dsum_q[63] ? -dsum_q : dsum_q;
    gsum     = {prod_q[31:0], 32'h0} + lp_q;
    if (prod_q[63:31] != '0) gsel = ONE_Q16;
    else if (gsum[63]) gsel = ONE_Q16;
    else gsel = {1'b0, gsum[62:47]};
    cmix     = chan(ca_q, ch_q) * (ONE_Q16 - g_q) + chan(cb_q, ch_q) * g_q;
    tn_full  = t_q * (ONE_Q16 - cover_q);
    tn       = tn_full[32:16];
    n_act    = (act_i > ACT_W'(MAX_LAYERS)) ? 5'(MAX_LAYERS) : 5'(act_i);
    last_layer = (k_q == '0);
    for (int i = 0; i < 3; i++) begin
      bgp = chan(bg_i, 2'(i)) * t_q;
      fs  = acc_q[i] + {bgp, 32'h0};
      fin_rgb[16 - 8 * i +: 8] = (fs[ACC_W-1:48] > 9'd255) ? 8'hFF : fs[55:48];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_BOX;
      k_q         <= '0;
      word_q      <= '0;
      sub_q       <= '0;
      fail_q      <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      t_q         <= ONE_Q16;
      cover_q     <= '0;
      g_q         <= '0;
      dsum_q      <= '0;
      prod_q      <= '0;
      lp_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      gabs_q      <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      c_q         <= '0;
      w_q         <= '0;
      ch_q        <= '0;
      acc_q       <= '{default: '0};
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            sx_q   <= {x_i, 16'h8000};
            sy_q   <= {y_i, 16'h8000};
            t_q    <= ONE_Q16;
            acc_q  <= '{default: '0};
            ph_q   <= PH_BOX;
            word_q <= WORD_W'(BOX_BASE);
            sub_q  <= '0;
            fail_q <= 1'b0;
            k_q    <= LAYER_W'(n_act - 5'd1);
            state_q <= (n_act == 5'd0) ? ST_FIN : ST_FETCH;
          end
        end
        ST_FETCH: begin
          dsum_q  <= dsum_q + prod_q;
          prod_q  <= '0;
          state_q <= ST_USE;
        end
        ST_USE: begin
          state_q <= ST_FETCH;
          word_q  <= word_q + WORD_W'(1);
          sub_q   <= sub_q + 3'd1;
          case (ph_q)
            PH_BOX: begin
              if (sub_q == 3'd3) begin
                if (fail_q || box_fail) begin
                  if (last_layer) state_q <= ST_FIN;
                  k_q    <= k_q - LAYER_W'(1);
                  word_q <= WORD_W'(BOX_BASE);
                  sub_q  <= '0;
                  fail_q <= 1'b0;
                end else begin
                  ph_q    <= PH_EDGE;
                  word_q  <= '0;
                  sub_q   <= '0;
                  cover_q <= ONE_Q16;
                end
              end else begin
                fail_q <= fail_q | box_fail;
              end
            end
            PH_EDGE: begin
              if (sub_q != 3'd2) begin
                prod_q <= 64'(eprod);
                if (sub_q == 3'd0) dsum_q <= '0;
              end else begin
                sub_q   <= '0;
                cover_q <= new_cov;
                if (dval <= NEG_HALF ||
                    (word_q == WORD_W'(BOX_BASE - 1) && new_cov == '0)) begin
                  if (last_layer) state_q <= ST_FIN;
                  k_q    <= k_q - LAYER_W'(1);
                  ph_q   <= PH_BOX;
                  word_q <= WORD_W'(BOX_BASE);
                  fail_q <= 1'b0;
                end else if (word_q == WORD_W'(BOX_BASE - 1)) begin
                  ph_q   <= PH_GRAD;
                  word_q <= WORD_W'(GRAD_BASE);
                end
              end
            end
            PH_GRAD: begin
              case (sub_q)
                3'd0: begin
                  dx_q   <= dsat;
                  dsum_q <= '0;
                end
                3'd1: dy_q <= dsat;
                3'd2, 3'd3: prod_q <= gprod;
                default: begin
                  ph_q   <= PH_COL;
                  word_q <= WORD_W'(COL_BASE);
                  sub_q  <= '0;
                  if (g_zero) begin
                    g_q <= '0;
                  end else begin
                    dsum_q  <= mabs;
                    gabs_q  <= rdata_i[31] ? (32'd0 - rdata_i) : rdata_i;
                    state_q <= ST_GH;
                  end
                end
              endcase
            end
            default: begin
              if (sub_q == 3'd0) begin
                ca_q <= rdata_i[23:0];
              end else begin
                cb_q    <= rdata_i[23:0];
                state_q <= ST_W;
              end
            end
          endcase
        end
        ST_GH: begin
          prod_q  <= $signed({32'h0, dsum_q[63:32]} * {32'h0, gabs_q});
          state_q <= ST_GL;
        end
        ST_GL: begin
          lp_q    <= {32'h0, dsum_q[31:0]} * {32'h0, gabs_q};
          state_q <= ST_GS;
        end
        ST_GS: begin
          g_q     <= gsel;
          prod_q  <= '0;
          state_q <= ST_FETCH;
        end
        ST_W: begin
          w_q     <= 33'(cover_q) * 33'(t_q);
          ch_q    <= '0;
          state_q <= ST_C;
        end
        ST_C: begin
          c_q     <= cmix[23:0];
          state_q <= ST_M;
        end
        ST_M: begin
          acc_q[ch_q] <= acc_q[ch_q] + ACC_W'(c_q) * ACC_W'(w_q);
          ch_q        <= ch_q + 2'd1;
          state_q     <= (ch_q == 2'd2) ? ST_T : ST_C;
        end
        ST_T: begin
          ph_q   <= PH_BOX;
          word_q <= WORD_W'(BOX_BASE);
          sub_q  <= '0;
          fail_q <= 1'b0;
          k_q    <= k_q - LAYER_W'(1);
          if (tn <= TRANSP_STOP) begin
            t_q     <= '0;
            state_q <= ST_FIN;
          end else begin
            t_q     <= tn;
            state_q <= last_layer ? ST_FIN : ST_FETCH;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            if (t_q == ONE_Q16) begin
              out_q.pixel_rgb <= bg_i;
              out_q.touched   <= 1'b0;
            end else begin
              out_q.pixel_rgb <= fin_rgb;
              out_q.touched   <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    req_o       = '0;
    req_o.rd    = (state_q == ST_FETCH);
    req_o.layer = k_q;
    req_o.word  = word_q;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hdl/ghc_checker.sv
module ghc_checker import ghc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_t                   in_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_t                  out_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [23:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= BG_RESET;
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i == CFG_BACKGROUND) begin
      bg_q <= cfg_data_i[23:0];
    end
  end

  // a result beat held back stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a shade beat blocks the input while the pass runs
  a_shade_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.cmd == CMD_SHADE |=> in_stall_o)
    else $error("input not stalled after a shade beat");

  // an untouched pixel shows the background colour
  a_plain_bg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.touched |-> out_o.pixel_rgb == bg_q)
    else $error("untouched pixel differs from background");

endmodule

bind gradient_hexagon_compositor_unit ghc_checker u_ghc_checker (.*);

FILE: sim/gradient_hexagon_compositor_unit_test.sv
`timescale 1ns / 100ps

module gradient_hexagon_compositor_unit_test import ghc_pkg::*;;

  // expected pixels in arrival order, plus a bit-true copy of the layer store
  class pixel_ledger;
    logic [31:0] params [MAX_LAYERS*WORDS_PER_LAYER];
    logic [23:0] bg_rgb;
    logic [3:0]  layer_count;
    out_t        pending [$];
    int          mismatches;
    int          shades;
    int          writes;
    int          touched_px;

    function new();
      bg_rgb      = BG_RESET;
      layer_count = ACTIVE_RESET;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_BACKGROUND) begin
        bg_rgb = data;
      end else begin
        layer_count = data[3:0];
      end
    endfunction

    function longint word_of(int k, int w);
      logic signed [31:0] s;
      s = params[k*WORDS_PER_LAYER + w];
      return longint'(s);
    endfunction

    function longint sat31(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
    endfunction

    // minimum over the edges of 0.5 plus distance, in Q16
    function longint layer_coverage(int k, longint fx, longint fy);
      longint cov_q;
      longint d;
      longint ce;
      cov_q = 65536;
      for (int e = 0; e < EDGES_PER_LAYER; e++) begin
        d = word_of(k, 3*e) * fx + word_of(k, 3*e+1) * fy + word_of(k, 3*e+2) * 65536;
        if (d <= -64'sd2147483648) return 0;
        if (d >= 64'sd2147483648) ce = 65536;
        else ce = (d + 64'sd2147483648) >>> 16;
        if (ce < cov_q) cov_q = ce;
      end
      return cov_q;
    endfunction

    // gradient position in Q16, clamped to 0..1
    function longint gradient_pos(int k, longint fx, longint fy);
      longint dx, dy, dot, gi;
      logic [127:0] mag, inv, prod;
      dx  = sat31(fx - word_of(k, GRAD_BASE));
      dy  = sat31(fy - word_of(k, GRAD_BASE+1));
      dot = dx * word_of(k, GRAD_BASE+2) + dy * word_of(k, GRAD_BASE+3);
      gi  = word_of(k, GRAD_BASE+4);
      if (dot == 0 || gi == 0) return 0;
      if ((dot < 0) != (gi < 0)) return 0;
      mag  = 128'((dot < 0) ? -dot : dot);
      inv  = 128'((gi < 0) ? -gi : gi);
      prod = mag * inv;
      if (prod >= (128'd1 << 63)) return 65536;
      return longint'(prod >> 47);
    endfunction

    function out_t composite(logic [9:0] px, logic [9:0] py);
      out_t        res;
      longint      fx, fy, cov_q, g;
      logic [63:0] acc [3];
      logic [63:0] w, c, a, b, v, transp;
      logic [23:0] ca, cb;
      int          n, sh;
      fx = longint'(px) * 65536 + 32768;
      fy = longint'(py) * 65536 + 32768;
      n  = (layer_count > MAX_LAYERS) ? MAX_LAYERS : layer_count;
      transp = 65536;
      for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
      for (int k = n - 1; k >= 0; k--) begin
        if (fx < word_of(k, BOX_BASE) - 32768 || fx > word_of(k, BOX_BASE+2) + 32768 ||
            fy < word_of(k, BOX_BASE+1) - 32768 || fy > word_of(k, BOX_BASE+3) + 32768)
          continue;
        cov_q = layer_coverage(k, fx, fy);
        if (cov_q == 0) continue;
        g  = gradient_pos(k, fx, fy);
        ca = params[k*WORDS_PER_LAYER + COL_BASE][23:0];
        cb = params[k*WORDS_PER_LAYER + COL_BASE+1][23:0];
        w  = cov_q * transp;
        for (int ch = 0; ch < 3; ch++) begin
          sh = 16 - 8*ch;
          a  = (ca >> sh) & 8'hFF;
          b  = (cb >> sh) & 8'hFF;
          c  = a * (65536 - g) + b * g;
          acc[ch] += c * w;
        end
        transp = (transp * (65536 - cov_q)) >> 16;
        if (transp <= TRANSP_STOP) begin
          transp = 0;
          break;
        end
      end
      if (transp >= 65536) begin
        res.pixel_rgb = bg_rgb;
        res.touched   = 1'b0;
        return res;
      end
      for (int ch = 0; ch < 3; ch++) begin
        sh = 16 - 8*ch;
        acc[ch] += (((bg_rgb >> sh) & 8'hFF) * transp) << 32;
        v = acc[ch] >> 48;
        if (v > 255) v = 255;
        res.pixel_rgb[sh +: 8] = v[7:0];
      end
      res.touched = 1'b1;
      return res;
    endfunction

    function void note_beat(in_t beat);
      if (beat.cmd == CMD_WRITE) begin
        params[beat.layer_index*WORDS_PER_LAYER + beat.word_index] = beat.word_value;
        writes++;
      end else begin
        pending.push_back(composite(beat.pixel_x, beat.pixel_y));
        shades++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel beat rgb=%06h touched=%0d", got.pixel_rgb, got.touched);
        return;
      end
      want = pending.pop_front();
      if (got.touched) touched_px++;
      if (got.pixel_rgb !== want.pixel_rgb || got.touched !== want.touched) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected rgb=%06h touched=%0d, got rgb=%06h touched=%0d",
                   want.pixel_rgb, want.touched, got.pixel_rgb, got.touched);
      end
    endfunction
  endclass

  localparam real PI = 3.14159265358979;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_beat = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_beat;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BACKGROUND;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_ledger ledger = new();

  gradient_hexagon_compositor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then a long hole
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stall pattern, with long stretches of no stall at all
  initial begin
    int run;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk_i);
      out_stall <= 1'b1;
      repeat (gap_len() + 1) @(posedge clk_i);
    end
  end

  // result monitor, sampled at the edge that takes the beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) ledger.check_result(out_beat);
  end

  // one input beat, then a random hole; valid stays up when there is no hole
  task automatic send_beat(in_t beat);
    int g;
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    ledger.note_beat(beat);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_word(int layer, int word, logic [31:0] value);
    in_t b;
    b.cmd         = CMD_WRITE;
    b.layer_index = 3'(layer);
    b.word_index  = 5'(word);
    b.word_value  = value;
    b.pixel_x     = 10'($urandom);
    b.pixel_y     = 10'($urandom);
    send_beat(b);
  endtask

  task automatic shade_pixel(int x, int y);
    in_t b;
    b.cmd         = CMD_SHADE;
    b.layer_index = 3'($urandom);
    b.word_index  = 5'($urandom);
    b.word_value  = $urandom;
    b.pixel_x     = 10'(x);
    b.pixel_y     = 10'(y);
    send_beat(b);
  endtask

  // a regular hexagon with a linear gradient; the odd layer is pure noise
  task automatic load_hexagon(int layer, real cx, real cy, real r, bit noisy);
    real rot, a, ax, ay, len, ang;
    int  sel;
    logic [31:0] ginv;
    if (noisy) begin
      for (int w = 0; w < WORDS_PER_LAYER; w++) write_word(layer, w, $urandom);
    end else begin
      rot = $urandom_range(0, 359) * PI / 180.0;
      for (int e = 0; e < EDGES_PER_LAYER; e++) begin
        a = rot + e * PI / 3.0;
        // inward normal, positive distance inside
        write_word(layer, 3*e,   int'(-$cos(a) * 65536.0));
        write_word(layer, 3*e+1, int'(-$sin(a) * 65536.0));
        write_word(layer, 3*e+2, int'((r + $cos(a)*cx + $sin(a)*cy) * 65536.0));
      end
      write_word(layer, BOX_BASE,   int'((cx - r) * 65536.0));
      write_word(layer, BOX_BASE+1, int'((cy - r) * 65536.0));
      write_word(layer, BOX_BASE+2, int'((cx + r) * 65536.0));
      write_word(layer, BOX_BASE+3, int'((cy + r) * 65536.0));
      ang = $urandom_range(0, 359) * PI / 180.0;
      len = 2.0 * r * ($urandom_range(50, 150) / 100.0);
      ax  = len * $cos(ang);
      ay  = len * $sin(ang);
      write_word(layer, GRAD_BASE,   int'((cx - ax/2.0) * 65536.0));
      write_word(layer, GRAD_BASE+1, int'((cy - ay/2.0) * 65536.0));
      write_word(layer, GRAD_BASE+2, int'(ax * 65536.0));
      write_word(layer, GRAD_BASE+3, int'(ay * 65536.0));
      ginv = int'(2147483648.0 / (len * len));
      sel  = $urandom_range(0, 9);
      // degenerate gradients: zero or sign-flipped reciprocal
      if (sel == 0) ginv = 0;
      else if (sel == 1) ginv = -ginv;
      write_word(layer, GRAD_BASE+4, ginv);
      write_word(layer, COL_BASE,   $urandom);
      write_word(layer, COL_BASE+1, $urandom);
      for (int w = COL_BASE + 2; w < WORDS_PER_LAYER; w++) write_word(layer, w, $urandom);
    end
  endtask

  // wait for every expected pixel, then a short settle before register writes
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    ledger.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic real jitter(int lo, int hi);
    return $urandom_range(lo, hi) + $urandom_range(0, 99) / 100.0;
  endfunction

  initial begin
    int counts [8] = '{8, 1, 0, 15, 6, 3, 8, 12};
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every word of every layer is loaded before the first shade
    for (int k = 0; k < MAX_LAYERS; k++) load_hexagon(k, 64.0, 64.0, 10.0 + 4.0*k, 1'b0);

    // directed: stacked layers at their centre, the rims, panel corners
    shade_pixel(64, 64);
    shade_pixel(63, 65);
    shade_pixel(64, 64 - 40);
    shade_pixel(64 + 30, 64);
    shade_pixel(64 - 20, 64 + 20);
    shade_pixel(0, 0);
    shade_pixel(1023, 1023);
    shade_pixel(0, 1023);
    shade_pixel(1023, 0);
    shade_pixel(512, 512);
    write_word(7, 31, 32'hFFFF_FFFF);
    write_word(0, 29, 32'h8000_0000);
    load_hexagon(5, 64.0, 64.0, 30.0, 1'b1);
    shade_pixel(64, 64);
    shade_pixel(40, 90);
    drain();

    // random phases, each with its own register setting
    for (int p = 0; p < 8; p++) begin
      write_register(CFG_BACKGROUND, (p == 0) ? 24'h000000 : (p == 1) ? 24'hFFFFFF :
                     CFG_DATA_W'($urandom));
      write_register(CFG_ACTIVE, CFG_DATA_W'(counts[p]));
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        load_hexagon($urandom_range(0, 7), jitter(10, 150), jitter(10, 150),
                     jitter(3, 50), $urandom_range(0, 9) == 0);
      for (int i = 0; i < 150; i++) begin
        case ($urandom_range(0, 9))
          0:       shade_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
          1:       write_word($urandom_range(0, 7), $urandom_range(29, 31), $urandom);
          default: shade_pixel($urandom_range(0, 159), $urandom_range(0, 159));
        endcase
      end
      drain();
    end

    repeat (600) @(posedge clk_i);
    $display("covered %0d parameter writes and %0d shaded pixels (%0d touched)",
             ledger.writes, ledger.shades, ledger.touched_px);
    $display("eight register phases with layer counts 0 to 15, %0d mismatches",
             ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
